>>> design/assert_macros.svh
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication check, disabled while in reset
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// next-cycle implication check, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

>>> design/sci_pkg.sv
// ----------------------------------------------------------------------------
// sci_pkg
// shared constants and types of the stepper command interpreter
// ----------------------------------------------------------------------------
package sci_pkg;
  localparam int LINE_BYTES_DEF = 16;
  localparam int COUNT_BITS_DEF = 16;
  localparam int RESET_PERIOD   = 790;

  localparam logic [3:0] OP_NONE  = 4'd0;
  localparam logic [3:0] OP_HELP  = 4'd1;
  localparam logic [3:0] OP_INFO  = 4'd2;
  localparam logic [3:0] OP_START = 4'd3;
  localparam logic [3:0] OP_STOP  = 4'd4;
  localparam logic [3:0] OP_SPEED = 4'd5;
  localparam logic [3:0] OP_DIR   = 4'd6;
  localparam logic [3:0] OP_SIZE  = 4'd7;
  localparam logic [3:0] OP_STEP  = 4'd8;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_CR  = 8'h0d;

  // controller to datapath
  typedef struct packed {
    logic store_wr;   // write byte at position
    logic pos_clear;  // line ended
    logic scan_clear; // start of line scan
    logic scan_step;  // take one stored char
    logic do_tick;    // tick update
    logic apply;      // commit parsed command
  } sci_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;  // last char of line being taken
    logic line_empty;
  } sci_stat_t;

  // character expected at index k of a command name, 0 beyond its end
  function automatic logic [7:0] name_char(input logic [3:0] cmd, input logic [2:0] k);
    logic [39:0] s;
    begin
      case (cmd)
        OP_HELP:  s = {"help", 8'h00};
        OP_INFO:  s = {"info", 8'h00};
        OP_START: s = "start";
        OP_STOP:  s = {"stop", 8'h00};
        OP_SPEED: s = "speed";
        OP_DIR:   s = {"dir", 16'h0};
        OP_SIZE:  s = {"size", 8'h00};
        OP_STEP:  s = {"step", 8'h00};
        default:  s = '0;
      endcase
      case (k)
        3'd0:    name_char = s[39:32];
        3'd1:    name_char = s[31:24];
        3'd2:    name_char = s[23:16];
        3'd3:    name_char = s[15:8];
        3'd4:    name_char = s[7:0];
        default: name_char = 8'h00;
      endcase
    end
  endfunction

  function automatic logic [2:0] name_len(input logic [3:0] cmd);
    begin
      case (cmd)
        OP_START, OP_SPEED: name_len = 3'd5;
        OP_DIR:             name_len = 3'd3;
        OP_NONE:            name_len = 3'd0;
        default:            name_len = 3'd4;
      endcase
    end
  endfunction
endpackage

>>> design/sci_ram.sv
// ----------------------------------------------------------------------------
// sci_ram
// generic simple dual-port ram (one write port, one read port) with registered read
// ----------------------------------------------------------------------------
module sci_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

>>> design/sci_datapath.sv
// ----------------------------------------------------------------------------
// sci_datapath
// line store, streaming command matcher, motor settings and tick counter
// ----------------------------------------------------------------------------
module sci_datapath #(
  parameter int LINE_BYTES = sci_pkg::LINE_BYTES_DEF,
  parameter int COUNT_BITS = sci_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sci_pkg::sci_cmd_t   cmd,
  output sci_pkg::sci_stat_t  stat,
  input  logic [7:0]          rx_byte,
  output logic [1:0]          step_pulses,
  output logic                direction_ccw,
  output logic                full_step,
  output logic                motor_on,
  output logic [3:0]          command_code,
  output logic                arg_unknown,
  output logic [15:0]         period_now,
  output logic [15:0]         steps_remaining
);
  import sci_pkg::*;

  localparam int AW = $clog2(LINE_BYTES);
  localparam int PW = $clog2(LINE_BYTES + 1);
  localparam int NC = 9; // candidates: ?, help..step

  logic [PW-1:0] pos_r, pos_nxt, len_r, len_nxt, idx_r, idx_nxt;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    ch;
  logic          run_r, dir_r, size_r;
  logic [COUNT_BITS-1:0] cnt_r, per_r, tick_r, num_r, num_nxt, tick_inc;
  logic [NC-1:0] live_r, live_nxt;      // bit 0 is '?', bit c is command c
  logic [1:0]    arg_ok_r, arg_ok_nxt;  // argument alternatives still matching
  logic [1:0]    pulses_r;
  logic [3:0]    code_r;
  logic          unk_r;
  logic [3:0]    win;
  logic [PW-1:0] arg_off;
  logic [2:0]    arg_k;
  logic          arg_in;
  logic [COUNT_BITS+3:0] prod;

  // effective write position wraps once full
  assign wr_addr = (pos_r >= PW'(LINE_BYTES)) ? '0 : pos_r[AW-1:0];
  assign rd_addr = idx_nxt[AW-1:0];

  sci_ram #(.WIDTH(8), .DEPTH(LINE_BYTES)) u_store (
    .clk(clk), .wr_en(cmd.store_wr), .wr_addr(wr_addr), .wr_data(rx_byte),
    .rd_addr(rd_addr), .rd_data(ch)
  );

  always_comb begin
    pos_nxt = pos_r;
    len_nxt = len_r;
    if (cmd.store_wr) begin
      pos_nxt = PW'(wr_addr) + 1'b1;
    end else if (cmd.pos_clear) begin
      len_nxt = (pos_r >= PW'(LINE_BYTES)) ? '0 : pos_r;
      pos_nxt = '0;
    end
  end

  // first candidate still live and fully held by the line decides the command
  always_comb begin
    win = OP_NONE;
    for (int c = NC-1; c >= 1; c--) begin
      if (live_r[c] && len_r >= PW'(name_len(4'(c)))) win = 4'(c);
    end
    if (live_r[0] && len_r != '0) win = OP_HELP;
  end

  // char position within argument, relative to winning name
  assign arg_in  = (idx_r >= PW'(name_len(win)));
  assign arg_off = idx_r - PW'(name_len(win));
  assign arg_k   = arg_off[2:0];
  assign prod    = (COUNT_BITS+4)'(num_r) * 4'd10 + (COUNT_BITS+4)'(ch - 8'h30);

  always_comb begin
    live_nxt   = live_r;
    arg_ok_nxt = arg_ok_r;
    num_nxt    = num_r;
    idx_nxt    = idx_r;
    if (cmd.scan_clear) begin
      live_nxt   = '1;
      arg_ok_nxt = 2'b11;
      num_nxt    = '0;
      idx_nxt    = '0;
    end else if (cmd.scan_step) begin
      idx_nxt = idx_r + 1'b1;
      if (idx_r == '0) live_nxt[0] = (ch == "?");
      else live_nxt[0] = live_r[0];
      for (int c = 1; c < NC; c++) begin
        if (idx_r < PW'(name_len(4'(c))) && ch != name_char(4'(c), 3'(idx_r)))
          live_nxt[c] = 1'b0;
      end
      if (arg_in) begin
        if (ch >= "0" && ch <= "9") num_nxt = prod[COUNT_BITS-1:0];
        if (arg_off < PW'(5)) begin
          if (win == OP_DIR && arg_k < 3'd3) begin
            if (ch != ((arg_k == 3'd0) ? 8'h20 : 8'h63)) arg_ok_nxt[1] = 1'b0;
            if (ch != ((arg_k == 3'd0) ? 8'h20 :
                       (arg_k == 3'd1) ? 8'h63 : 8'h77)) arg_ok_nxt[0] = 1'b0;
          end
          if (win == OP_SIZE) begin
            case (arg_k)
              3'd0: if (ch != 8'h20) arg_ok_nxt = 2'b00;
              3'd1: begin
                if (ch != "f") arg_ok_nxt[1] = 1'b0;
                if (ch != "h") arg_ok_nxt[0] = 1'b0;
              end
              3'd2: begin
                if (ch != "u") arg_ok_nxt[1] = 1'b0;
                if (ch != "a") arg_ok_nxt[0] = 1'b0;
              end
              3'd3: if (ch != "l") arg_ok_nxt = 2'b00;
              default: begin
                if (ch != "l") arg_ok_nxt[1] = 1'b0;
                if (ch != "f") arg_ok_nxt[0] = 1'b0;
              end
            endcase
          end
        end
      end
    end
  end

  // the argument must be long enough to hold a full alternative
  logic [2:0] alt_len;
  logic       has_arg, alt_full;
  assign alt_len  = (win == OP_DIR) ? 3'd3 : 3'd5;
  assign has_arg  = len_r > PW'(name_len(win));
  assign alt_full = (len_r - PW'(name_len(win))) >= PW'(alt_len);

  assign tick_inc = tick_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      run_r    <= 1'b0;
      cnt_r    <= '0;
      per_r    <= COUNT_BITS'(RESET_PERIOD);
      tick_r   <= '0;
      dir_r    <= 1'b0;
      size_r   <= 1'b1;
      pulses_r <= '0;
      code_r   <= OP_NONE;
      unk_r    <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      if (cmd.store_wr || cmd.scan_clear) begin
        pulses_r <= '0;
        code_r   <= OP_NONE;
        unk_r    <= 1'b0;
      end
      if (cmd.do_tick) begin
        code_r <= OP_NONE;
        unk_r  <= 1'b0;
        if (tick_inc == per_r) begin
          tick_r   <= '0;
          pulses_r <= 2'(run_r) + 2'(cnt_r != '0);
          if (cnt_r != '0) cnt_r <= cnt_r - 1'b1;
        end else begin
          tick_r   <= tick_inc;
          pulses_r <= '0;
        end
      end
      if (cmd.apply) begin
        code_r <= win;
        case (win)
          OP_START: run_r <= 1'b1;
          OP_STOP: begin
            run_r <= 1'b0;
            cnt_r <= '0;
          end
          OP_SPEED: if (num_r >= COUNT_BITS'(3)) begin
            per_r  <= num_r;
            tick_r <= '0;
          end
          OP_STEP: if (num_r != '0) begin
            cnt_r <= num_r;
            run_r <= 1'b0;
          end
          OP_DIR: if (has_arg) begin
            if (alt_full && arg_ok_r[1]) dir_r <= 1'b1;
            else if (alt_full && arg_ok_r[0]) dir_r <= 1'b0;
            else unk_r <= 1'b1;
          end
          OP_SIZE: if (has_arg) begin
            if (alt_full && arg_ok_r[1]) size_r <= 1'b1;
            else if (alt_full && arg_ok_r[0]) size_r <= 1'b0;
            else unk_r <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    len_r    <= len_nxt;
    idx_r    <= idx_nxt;
    live_r   <= live_nxt;
    arg_ok_r <= arg_ok_nxt;
    num_r    <= num_nxt;
  end

  assign stat.scan_last  = (idx_r + 1'b1) >= len_r;
  assign stat.line_empty = (len_r == '0);

  assign step_pulses     = pulses_r;
  assign direction_ccw   = dir_r;
  assign full_step       = size_r;
  assign motor_on        = run_r || (cnt_r != '0);
  assign command_code    = code_r;
  assign arg_unknown     = unk_r;
  assign period_now      = 16'(per_r);
  assign steps_remaining = 16'(cnt_r);
endmodule

>>> design/sci_ctrl.sv
// ----------------------------------------------------------------------------
// sci_ctrl
// sequencer: takes a request, walks the line on a terminator, holds result
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sci_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               line_done,
  output sci_pkg::sci_cmd_t  cmd,
  input  sci_pkg::sci_stat_t stat
);
  import sci_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PRIME = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_APPLY = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       done_r, done_nxt;
  logic       take, term;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign line_done = done_r;
  assign take = in_valid && in_ready;
  assign term = (in_rx_byte == CH_NUL) || (in_rx_byte == CH_LF) || (in_rx_byte == CH_CR);

  always_comb begin
    state_nxt = state_r;
    done_nxt  = done_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: if (take) begin
        done_nxt = 1'b0;
        if (in_mode) begin
          cmd.do_tick = 1'b1;
          state_nxt   = S_OUT;
        end else if (term) begin
          cmd.pos_clear = 1'b1;
          done_nxt      = 1'b1;
          state_nxt     = S_PRIME;
        end else begin
          cmd.store_wr = 1'b1;
          state_nxt    = S_OUT;
        end
      end
      S_PRIME: begin
        // first stored char is read while the scan registers clear
        cmd.scan_clear = 1'b1;
        state_nxt = stat.line_empty ? S_APPLY : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  `ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ready, !out_valid)
  `ASSERT_NEXT(a_tick_out, clk, rst_n, take && in_mode, out_valid && !line_done)
  `ASSERT_NEXT(a_term_scan, clk, rst_n, take && !in_mode && term, state_r == S_PRIME)
endmodule

>>> design/stepper_command_interpreter.sv
// ----------------------------------------------------------------------------
// stepper_command_interpreter
// serial command line parser and step-rate generator for a stepper driver
// ----------------------------------------------------------------------------
// One request at a time: a tick or a stored byte has its result valid in the
// cycle after acceptance; a line terminator walks the stored line one
// character per cycle through the line ram read port (a prime state starts the
// read, a scan state takes each character, an apply state commits the command),
// and its result is then held until taken.
// A new request is taken in the cycle after the result is taken.
module stepper_command_interpreter #(
  parameter int LINE_BYTES = sci_pkg::LINE_BYTES_DEF,
  parameter int COUNT_BITS = sci_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_step_pulses,
  output logic        out_direction_ccw,
  output logic        out_full_step,
  output logic        out_motor_on,
  output logic        out_line_done,
  output logic [3:0]  out_command_code,
  output logic        out_arg_unknown,
  output logic [15:0] out_period_now,
  output logic [15:0] out_steps_remaining
);
  import sci_pkg::*;

  sci_cmd_t  cmd;
  sci_stat_t stat;

  sci_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_mode(in_mode), .in_rx_byte(in_rx_byte), .out_valid(out_valid),
    .out_ready(out_ready), .line_done(out_line_done), .cmd(cmd), .stat(stat)
  );

  sci_datapath #(.LINE_BYTES(LINE_BYTES), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .rx_byte(in_rx_byte),
    .step_pulses(out_step_pulses), .direction_ccw(out_direction_ccw),
    .full_step(out_full_step), .motor_on(out_motor_on),
    .command_code(out_command_code), .arg_unknown(out_arg_unknown),
    .period_now(out_period_now), .steps_remaining(out_steps_remaining)
  );
endmodule

>>> bench/tb_stepper_command_interpreter.sv
// ----------------------------------------------------------------------------
// tb_stepper_command_interpreter
// checks the command parser and the step-rate generator against a predictor
// of the line store, the prefix matcher, the settings and the tick counter,
// using command lines with random arguments, noise bytes and tick bursts
// ----------------------------------------------------------------------------
module tb_stepper_command_interpreter;
  timeunit 1ns;
  timeprecision 1ps;
  import sci_pkg::*;

  localparam int LINE_LEN    = 16;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic [1:0]  pulses;
    logic        ccw;
    logic        full;
    logic        motor;
    logic        done;
    logic [3:0]  code;
    logic        unknown;
    logic [15:0] period;
    logic [15:0] steps;
  } motor_status_t;

  class motor_scoreboard;
    logic [7:0]    line_mem [LINE_LEN];
    int            pos;
    bit            run;
    logic [15:0]   steps;
    logic [15:0]   period;
    logic [15:0]   ticks;
    bit            ccw;
    bit            full;
    motor_status_t status_q [$];
    int            errors;

    function new();
      pos = 0;
      run = 0;
      steps = '0;
      period = 16'(RESET_PERIOD);
      ticks = '0;
      ccw = 0;
      full = 1;
      errors = 0;
      foreach (line_mem[i]) line_mem[i] = '0;
    endfunction

    function bit line_has(string lit, int off, int len);
      int k;
      for (int i = 0; i < lit.len(); i++) begin
        k = off + i;
        if (k >= len || k >= LINE_LEN) return 0;
        if (line_mem[k] != lit[i]) return 0;
      end
      return 1;
    endfunction

    function logic [15:0] line_number(int off, int len);
      logic [31:0] r;
      r = 0;
      for (int k = off; k < len && k < LINE_LEN; k++) begin
        if (line_mem[k] >= "0" && line_mem[k] <= "9")
          r = ((r * 10) + (line_mem[k] - "0")) & 32'hffff;
      end
      return r[15:0];
    endfunction

    function logic [3:0] run_line(int len, output bit unknown);
      logic [15:0] v;
      unknown = 0;
      if (line_has("?", 0, len) || line_has("help", 0, len)) return OP_HELP;
      if (line_has("info", 0, len)) return OP_INFO;
      if (line_has("start", 0, len)) begin
        run = 1;
        return OP_START;
      end
      if (line_has("stop", 0, len)) begin
        run = 0;
        steps = '0;
        return OP_STOP;
      end
      if (line_has("speed", 0, len)) begin
        v = line_number(5, len);
        if (v >= 3) begin
          period = v;
          ticks = '0;
        end
        return OP_SPEED;
      end
      if (line_has("dir", 0, len)) begin
        if (len > 3) begin
          if (line_has(" cc", 3, len)) ccw = 1;
          else if (line_has(" cw", 3, len)) ccw = 0;
          else unknown = 1;
        end
        return OP_DIR;
      end
      if (line_has("size", 0, len)) begin
        if (len > 4) begin
          if (line_has(" full", 4, len)) full = 1;
          else if (line_has(" half", 4, len)) full = 0;
          else unknown = 1;
        end
        return OP_SIZE;
      end
      if (line_has("step", 0, len)) begin
        v = line_number(4, len);
        if (v != 0) begin
          steps = v;
          run = 0;
        end
        return OP_STEP;
      end
      return OP_NONE;
    endfunction

    function void note_request(bit tick, logic [7:0] ch);
      motor_status_t s;
      int len;
      bit unk;
      s.pulses = 0;
      s.done = 0;
      s.code = OP_NONE;
      s.unknown = 0;
      if (!tick) begin
        if (pos >= LINE_LEN) pos = 0;
        if (ch == CH_NUL || ch == CH_LF || ch == CH_CR) begin
          len = pos;
          pos = 0;
          s.done = 1;
          s.code = run_line(len, unk);
          s.unknown = unk;
        end else begin
          line_mem[pos] = ch;
          pos++;
        end
      end else begin
        ticks = ticks + 1;
        if (ticks == period) begin
          ticks = '0;
          if (run) s.pulses++;
          if (steps != 0) begin
            steps = steps - 1;
            s.pulses++;
          end
        end
      end
      s.ccw = ccw;
      s.full = full;
      s.motor = run || (steps != 0);
      s.period = period;
      s.steps = steps;
      status_q.push_back(s);
    endfunction

    function void check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(motor_status_t got);
      motor_status_t e;
      if (status_q.size() == 0) begin
        $display("%0t: unexpected result, expected nothing, got code %0d", $time,
                 got.code);
        errors++;
        return;
      end
      e = status_q.pop_front();
      check_field("step_pulses", e.pulses, got.pulses);
      check_field("direction_ccw", e.ccw, got.ccw);
      check_field("full_step", e.full, got.full);
      check_field("motor_on", e.motor, got.motor);
      check_field("line_done", e.done, got.done);
      check_field("command_code", e.code, got.code);
      check_field("arg_unknown", e.unknown, got.unknown);
      check_field("period_now", e.period, got.period);
      check_field("steps_remaining", e.steps, got.steps);
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic        in_mode = 0;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [1:0]  out_step_pulses;
  logic        out_direction_ccw;
  logic        out_full_step;
  logic        out_motor_on;
  logic        out_line_done;
  logic [3:0]  out_command_code;
  logic        out_arg_unknown;
  logic [15:0] out_period_now;
  logic [15:0] out_steps_remaining;

  motor_scoreboard sb = new();
  int  send_idle_pct = 6;
  int  recv_idle_pct = 69;
  bit  hold_req = 0;
  int  sent = 0;
  int  cycles = 0;

  always #5 clk = ~clk;

  stepper_command_interpreter dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_step_pulses    (out_step_pulses),
    .out_direction_ccw  (out_direction_ccw),
    .out_full_step      (out_full_step),
    .out_motor_on       (out_motor_on),
    .out_line_done      (out_line_done),
    .out_command_code   (out_command_code),
    .out_arg_unknown    (out_arg_unknown),
    .out_period_now     (out_period_now),
    .out_steps_remaining(out_steps_remaining)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : receiver
    int hold;
    motor_status_t got;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold_req && hold == 0) begin
        hold = 300;
        hold_req = 0;
      end
      if (hold > 0) begin
        hold--;
        out_ready = 0;
      end else begin
        out_ready = rst_n && ($urandom_range(99) >= recv_idle_pct);
      end
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.pulses = out_step_pulses;
        got.ccw = out_direction_ccw;
        got.full = out_full_step;
        got.motor = out_motor_on;
        got.done = out_line_done;
        got.code = out_command_code;
        got.unknown = out_arg_unknown;
        got.period = out_period_now;
        got.steps = out_steps_remaining;
        sb.check_result(got);
      end
    end
  end

  task automatic send_req(bit tick, logic [7:0] ch);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1;
    in_mode = tick;
    in_rx_byte = tick ? 8'($urandom) : ch;
    do @(posedge clk); while (!in_ready);
    sb.note_request(tick, ch);
    sent++;
  endtask

  task automatic send_text(string s, logic [7:0] term);
    for (int i = 0; i < s.len(); i++) send_req(0, s[i]);
    send_req(0, term);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_req(1, 8'h00);
  endtask

  function automatic logic [7:0] pick_term();
    case ($urandom_range(2))
      0: return CH_NUL;
      1: return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic string random_line();
    string dir_args [6] = '{"", " cc", " cw", " ccw", " x", " c"};
    string size_args [6] = '{"", " full", " half", " fu", " zz", " fullx"};
    int v;
    case ($urandom_range(11))
      0: return ($urandom_range(1)) ? "?" : "help me";
      1: return "info";
      2: return "start";
      3: return "stop";
      4, 5: begin
        v = ($urandom_range(3) == 0) ? $urandom_range(0, 99999) : $urandom_range(0, 12);
        return $sformatf("speed %0d", v);
      end
      6: return {"dir", dir_args[$urandom_range(5)]};
      7: return {"size", size_args[$urandom_range(5)]};
      8, 9: begin
        v = ($urandom_range(4) == 0) ? $urandom_range(0, 70000) : $urandom_range(0, 6);
        return ($urandom_range(5) == 0) ? $sformatf("step %0da1", v)
                                         : $sformatf("step %0d", v);
      end
      10: return "stepp 2";
      default: return "sta";
    endcase
  endfunction

  task automatic random_traffic(int quota);
    int target;
    int n;
    target = sent + quota;
    while (sent < target) begin
      case ($urandom_range(9))
        0: begin
          // noise, any nonzero byte value
          n = $urandom_range(0, 20);
          repeat (n) send_req(0, 8'($urandom_range(1, 255)));
          send_req(0, pick_term());
        end
        1, 2, 3: send_ticks($urandom_range(1, 20));
        default: send_text(random_line(), pick_term());
      endcase
    end
  endtask

  initial begin : sender
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed lines
    send_text("speed 3", CH_CR);
    send_text("step 2", CH_LF);
    send_ticks(7);
    send_text("start", CH_NUL);
    send_ticks(3);
    send_text("dir cc", CH_LF);
    send_text("dir q", CH_LF);
    send_text("size half", CH_CR);
    send_text("size", CH_CR);
    send_text("?", CH_LF);
    send_text("info", CH_LF);
    send_text("", CH_CR);
    send_text("speed 99999", CH_LF);
    send_text("speed 2", CH_LF);
    send_text("step 0", CH_LF);
    send_text("stop", CH_LF);
    // line longer than the store wraps onto itself
    send_text("xxxxxxxxxxxxxxxxhelp", CH_LF);

    random_traffic(350);

    send_idle_pct = 69;
    recv_idle_pct = 6;
    hold_req = 1;
    random_traffic(200);
    // let everything drain before going on
    @(negedge clk);
    in_valid = 0;
    while (sb.status_q.size() != 0) @(posedge clk);
    random_traffic(200);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_traffic(400);

    @(negedge clk);
    in_valid = 0;
    while (sb.status_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.status_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
